// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the chunk cache checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside of reset.
`define LCC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chunk cache check failed");

// Next-cycle implication, sampled on the rising clock edge outside of reset.
`define LCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chunk cache check failed");

`endif

// ===== hdl/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg
// Types, codes and widths shared by the chunk cache modules.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int ENTRIES_DEF     = 32;
  localparam int CHUNK_BYTES_DEF = 4194304;

  localparam int FILE_W      = 16;
  localparam int CHUNK_W     = 24;
  localparam int SIZE_W      = 23;
  localparam int STAMP_W     = 64;
  localparam int BUDGET_W    = 41;
  localparam int SLOT_W      = 5;
  localparam int COUNT_W     = 6;
  localparam int TOTAL_OUT_W = 28;
  // Entry indexes and counts for any table size up to 63 entries.
  localparam int IDX_MAX_W   = 6;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 41'd268435456;

  typedef enum logic [1:0] {
    MODE_ACCESS = 2'd0,
    MODE_INVAL  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_TRIM   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_HIT    = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_FAIL   = 3'd2,
    KIND_EVICT  = 3'd3,
    KIND_INVAL  = 3'd4,
    KIND_CLEAR  = 3'd5,
    KIND_TRIM   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_INSERT
  } state_t;

  typedef struct packed {
    logic [FILE_W-1:0]  file;
    logic [CHUNK_W-1:0] chunk;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic                 hit_found;
    logic [IDX_MAX_W-1:0] hit_slot;
    logic [SIZE_W-1:0]    hit_size;
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_slot;
    logic                 old_found;
    logic [IDX_MAX_W-1:0] old_slot;
    logic [FILE_W-1:0]    old_file;
    logic [CHUNK_W-1:0]   old_chunk;
    logic [SIZE_W-1:0]    old_size;
    logic [COUNT_W-1:0]   valid_cnt;
    logic [COUNT_W-1:0]   file_cnt;
  } scan_res_t;

endpackage

// ===== hdl/lcc_table.sv =====
// ----------------------------------------------------------------------------
// lcc_table
// Entry storage: one write port, one registered read port, valid flags.
// ----------------------------------------------------------------------------
module lcc_table #(
  parameter int ENTRIES = lcc_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output lcc_pkg::entry_t            rd_data_r,
  output logic                       rd_vld_r,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  lcc_pkg::entry_t            wr_data,
  input  logic                       clr_en,
  input  logic [$clog2(ENTRIES)-1:0] clr_addr,
  input  logic                       clr_all
);

  lcc_pkg::entry_t    mem_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // A write marks the entry valid and wins over a single clear; clear-all wins over everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
      if (clr_all) begin
        valid_r <= '0;
      end else begin
        if (clr_en) begin
          valid_r[clr_addr] <= 1'b0;
        end
        if (wr_en) begin
          valid_r[wr_addr] <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/lcc_scan.sv =====
// ----------------------------------------------------------------------------
// lcc_scan
// Walks the table one entry a cycle and gathers lookup and victim results.
// ----------------------------------------------------------------------------
module lcc_scan #(
  parameter int ENTRIES = lcc_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lcc_pkg::FILE_W-1:0]  key_file,
  input  logic [lcc_pkg::CHUNK_W-1:0] key_chunk,
  output logic [$clog2(ENTRIES)-1:0]  rd_addr,
  input  lcc_pkg::entry_t             ent,
  input  logic                        ent_vld,
  output logic                        done,
  output logic                        drop_now,
  output logic [$clog2(ENTRIES)-1:0]  drop_slot,
  output lcc_pkg::scan_res_t          res
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int IW    = lcc_pkg::IDX_MAX_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  logic                          run_r;
  logic [IDX_W-1:0]              addr_r;
  logic                          dv_r;
  logic [IDX_W-1:0]              didx_r;
  lcc_pkg::scan_res_t            res_r;
  lcc_pkg::scan_res_t            res_nxt;
  logic [lcc_pkg::STAMP_W-1:0]   old_stamp_r;
  logic [lcc_pkg::STAMP_W-1:0]   old_stamp_nxt;
  logic                          live;
  logic                          file_m;
  logic                          older;

  assign rd_addr   = addr_r;
  assign done      = dv_r && (didx_r == LAST);
  assign drop_now  = file_m;
  assign drop_slot = didx_r;
  assign res       = res_r;

  assign live   = dv_r && ent_vld;
  assign file_m = live && (ent.file == key_file);
  // Strict compare while walking upward keeps the lowest slot on a tie.
  assign older  = live && (!res_r.old_found || (ent.stamp < old_stamp_r));

  always_comb begin
    res_nxt       = res_r;
    old_stamp_nxt = old_stamp_r;
    if (file_m && (ent.chunk == key_chunk) && !res_r.hit_found) begin
      res_nxt.hit_found = 1'b1;
      res_nxt.hit_slot  = IW'(didx_r);
      res_nxt.hit_size  = ent.size;
    end
    if (dv_r && !ent_vld && !res_r.free_found) begin
      res_nxt.free_found = 1'b1;
      res_nxt.free_slot  = IW'(didx_r);
    end
    if (older) begin
      res_nxt.old_found = 1'b1;
      res_nxt.old_slot  = IW'(didx_r);
      res_nxt.old_file  = ent.file;
      res_nxt.old_chunk = ent.chunk;
      res_nxt.old_size  = ent.size;
      old_stamp_nxt     = ent.stamp;
    end
    if (live) begin
      res_nxt.valid_cnt = res_r.valid_cnt + 1'b1;
    end
    if (file_m) begin
      res_nxt.file_cnt = res_r.file_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      dv_r   <= 1'b0;
      addr_r <= '0;
    end else begin
      dv_r <= run_r;
      if (start) begin
        run_r  <= 1'b1;
        addr_r <= '0;
      end else if (run_r) begin
        if (addr_r == LAST) begin
          run_r <= 1'b0;
        end else begin
          addr_r <= addr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= addr_r;
    if (start) begin
      res_r       <= '0;
      old_stamp_r <= '0;
    end else begin
      res_r       <= res_nxt;
      old_stamp_r <= old_stamp_nxt;
    end
  end

endmodule

// ===== hdl/lru_chunk_cache_byte_budget.sv =====
// ----------------------------------------------------------------------------
// lru_chunk_cache_byte_budget
// Chunk cache bookkeeping with least-recently-used eviction under a budget.
// A request is one transfer on the in_ channel: access, invalidate file,
// clear all, or trim to budget. Each request produces one or more result
// transfers on the out_ channel; out_last marks the final one. in_ready is
// high only while no request is in work. Every request scans the table at
// least once, one entry a cycle through a single read port and compare unit.
// Each eviction under budget pressure rescans the table; evicting from a full
// table reuses the victim slot for the insert without a rescan. The budget is
// written through cfg_we/cfg_wdata and is raised to one chunk if smaller; the
// user must write it only while idle, which the block does not enforce. A
// stalled receiver holds the result register and the sequencer waits.
// Synchronous reset empties the table, zeroes the byte total and stamp and
// restores the default budget.
// ----------------------------------------------------------------------------
module lru_chunk_cache_byte_budget #(
  parameter int ENTRIES     = lcc_pkg::ENTRIES_DEF,
  parameter int CHUNK_BYTES = lcc_pkg::CHUNK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic [lcc_pkg::FILE_W-1:0]      in_file_id,
  input  logic [lcc_pkg::CHUNK_W-1:0]     in_chunk_index,
  input  logic [lcc_pkg::SIZE_W-1:0]      in_fetched_bytes,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_kind,
  output logic [lcc_pkg::FILE_W-1:0]      out_file,
  output logic [lcc_pkg::CHUNK_W-1:0]     out_chunk,
  output logic [lcc_pkg::SLOT_W-1:0]      out_slot,
  output logic [lcc_pkg::SIZE_W-1:0]      out_entry_bytes,
  output logic [lcc_pkg::COUNT_W-1:0]     out_removed_count,
  output logic [lcc_pkg::TOTAL_OUT_W-1:0] out_total_bytes,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [lcc_pkg::BUDGET_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  // One spare chunk of headroom: the total briefly holds a new chunk on top
  // of a full table before evictions bring it down.
  localparam int TOT_W = $clog2((ENTRIES + 1) * CHUNK_BYTES + 1);
  localparam int IW    = lcc_pkg::IDX_MAX_W;
  localparam int SW    = lcc_pkg::SIZE_W;
  localparam int BW    = lcc_pkg::BUDGET_W;
  localparam int OTW   = lcc_pkg::TOTAL_OUT_W;
  localparam int SLW   = lcc_pkg::SLOT_W;
  localparam logic [SW-1:0] CHUNK_SZ  = SW'(CHUNK_BYTES);
  localparam logic [BW-1:0] CHUNK_BUD = BW'(CHUNK_BYTES);

  lcc_pkg::state_t                state_r, state_nxt;
  lcc_pkg::mode_t                 mode_r;
  logic [lcc_pkg::FILE_W-1:0]     file_r;
  logic [lcc_pkg::CHUNK_W-1:0]    chunk_r;
  logic [SW-1:0]                  fetch_r;
  logic                           added_r, added_nxt;
  logic                           full_r, full_nxt;
  logic [lcc_pkg::STAMP_W-1:0]    stamp_r, stamp_nxt;
  logic [TOT_W-1:0]               total_r, total_nxt;
  logic [BW-1:0]                  budget_r;
  logic [IW-1:0]                  ins_slot_r, ins_slot_nxt;

  logic                           out_valid_r;
  lcc_pkg::kind_t                 out_kind_r;
  logic [lcc_pkg::FILE_W-1:0]     out_file_r;
  logic [lcc_pkg::CHUNK_W-1:0]    out_chunk_r;
  logic [SLW-1:0]                 out_slot_r;
  logic [SW-1:0]                  out_bytes_r;
  logic [lcc_pkg::COUNT_W-1:0]    out_count_r;
  logic [OTW-1:0]                 out_total_r;
  logic                           out_last_r;

  logic                           out_free;
  logic                           over;
  logic                           accept;

  logic                           scan_start;
  logic                           scan_done;
  logic                           drop_now;
  logic [IDX_W-1:0]               drop_slot;
  lcc_pkg::scan_res_t             res;
  logic [IDX_W-1:0]               rd_addr;
  lcc_pkg::entry_t                rd_data;
  logic                           rd_vld;

  logic                           tbl_wr;
  logic [IDX_W-1:0]               tbl_wr_addr;
  lcc_pkg::entry_t                tbl_wr_data;
  logic                           tbl_clr;
  logic [IDX_W-1:0]               tbl_clr_addr;
  logic                           tbl_clr_all;

  logic                           out_load;
  lcc_pkg::kind_t                 ld_kind;
  logic [lcc_pkg::FILE_W-1:0]     ld_file;
  logic [lcc_pkg::CHUNK_W-1:0]    ld_chunk;
  logic [IW-1:0]                  ld_slot;
  logic [SW-1:0]                  ld_bytes;
  logic [lcc_pkg::COUNT_W-1:0]    ld_count;
  logic                           ld_last;

  lcc_table #(.ENTRIES(ENTRIES)) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data),
    .rd_vld_r  (rd_vld),
    .wr_en     (tbl_wr),
    .wr_addr   (tbl_wr_addr),
    .wr_data   (tbl_wr_data),
    .clr_en    (tbl_clr),
    .clr_addr  (tbl_clr_addr),
    .clr_all   (tbl_clr_all)
  );

  lcc_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .key_file  (file_r),
    .key_chunk (chunk_r),
    .rd_addr   (rd_addr),
    .ent       (rd_data),
    .ent_vld   (rd_vld),
    .done      (scan_done),
    .drop_now  (drop_now),
    .drop_slot (drop_slot),
    .res       (res)
  );

  assign in_ready = (state_r == lcc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign over     = BW'(total_r) > budget_r;

  // Sequencer: one table scan per pass, then a decision on what the pass
  // found. Evictions under budget pressure rescan; the full-table eviction
  // reuses the victim slot for the insert directly.
  always_comb begin
    state_nxt    = state_r;
    added_nxt    = added_r;
    full_nxt     = full_r;
    stamp_nxt    = stamp_r;
    total_nxt    = total_r;
    ins_slot_nxt = ins_slot_r;
    scan_start   = 1'b0;
    tbl_wr       = 1'b0;
    tbl_wr_addr  = IDX_W'(ins_slot_r);
    tbl_wr_data  = '{file: file_r, chunk: chunk_r, size: fetch_r,
                     stamp: stamp_r + 1'b1};
    tbl_clr      = 1'b0;
    tbl_clr_addr = drop_slot;
    tbl_clr_all  = 1'b0;
    out_load     = 1'b0;
    ld_kind      = lcc_pkg::KIND_HIT;
    ld_file      = '0;
    ld_chunk     = '0;
    ld_slot      = '0;
    ld_bytes     = '0;
    ld_count     = '0;
    ld_last      = 1'b1;

    unique case (state_r)
      lcc_pkg::ST_IDLE: begin
        if (in_valid) begin
          scan_start = 1'b1;
          added_nxt  = 1'b0;
          full_nxt   = 1'b0;
          state_nxt  = lcc_pkg::ST_SCAN;
        end
      end

      lcc_pkg::ST_SCAN: begin
        // Invalidate drops matching entries as the scan passes them.
        if (drop_now && (mode_r == lcc_pkg::MODE_INVAL)) begin
          tbl_clr   = 1'b1;
          total_nxt = (total_r >= TOT_W'(rd_data.size)) ?
                      total_r - TOT_W'(rd_data.size) : '0;
        end
        if (scan_done) begin
          state_nxt = lcc_pkg::ST_DECIDE;
        end
      end

      lcc_pkg::ST_DECIDE: begin
        unique case (mode_r)
          lcc_pkg::MODE_ACCESS: begin
            if (!added_r) begin
              if (res.hit_found) begin
                if (out_free) begin
                  tbl_wr            = 1'b1;
                  tbl_wr_addr       = IDX_W'(res.hit_slot);
                  tbl_wr_data.size  = res.hit_size;
                  stamp_nxt         = stamp_r + 1'b1;
                  out_load          = 1'b1;
                  ld_kind           = lcc_pkg::KIND_HIT;
                  ld_file           = file_r;
                  ld_chunk          = chunk_r;
                  ld_slot           = res.hit_slot;
                  ld_bytes          = res.hit_size;
                  state_nxt         = lcc_pkg::ST_IDLE;
                end
              end else if (fetch_r == '0) begin
                if (out_free) begin
                  out_load  = 1'b1;
                  ld_kind   = lcc_pkg::KIND_FAIL;
                  ld_file   = file_r;
                  ld_chunk  = chunk_r;
                  state_nxt = lcc_pkg::ST_IDLE;
                end
              end else begin
                total_nxt = total_r + TOT_W'(fetch_r);
                added_nxt = 1'b1;
              end
            end else if (over && res.old_found) begin
              state_nxt = lcc_pkg::ST_EVICT;
            end else if (!res.free_found) begin
              full_nxt  = 1'b1;
              state_nxt = lcc_pkg::ST_EVICT;
            end else begin
              ins_slot_nxt = res.free_slot;
              state_nxt    = lcc_pkg::ST_INSERT;
            end
          end
          lcc_pkg::MODE_INVAL: begin
            if (out_free) begin
              out_load  = 1'b1;
              ld_kind   = lcc_pkg::KIND_INVAL;
              ld_file   = file_r;
              ld_count  = res.file_cnt;
              state_nxt = lcc_pkg::ST_IDLE;
            end
          end
          lcc_pkg::MODE_CLEAR: begin
            if (out_free) begin
              tbl_clr_all = 1'b1;
              total_nxt   = '0;
              out_load    = 1'b1;
              ld_kind     = lcc_pkg::KIND_CLEAR;
              ld_count    = res.valid_cnt;
              state_nxt   = lcc_pkg::ST_IDLE;
            end
          end
          lcc_pkg::MODE_TRIM: begin
            if (over && res.old_found) begin
              state_nxt = lcc_pkg::ST_EVICT;
            end else if (out_free) begin
              out_load  = 1'b1;
              ld_kind   = lcc_pkg::KIND_TRIM;
              state_nxt = lcc_pkg::ST_IDLE;
            end
          end
          default: begin
            state_nxt = lcc_pkg::ST_IDLE;
          end
        endcase
      end

      lcc_pkg::ST_EVICT: begin
        if (out_free) begin
          tbl_clr      = 1'b1;
          tbl_clr_addr = IDX_W'(res.old_slot);
          total_nxt    = (total_r >= TOT_W'(res.old_size)) ?
                         total_r - TOT_W'(res.old_size) : '0;
          out_load     = 1'b1;
          ld_kind      = lcc_pkg::KIND_EVICT;
          ld_file      = res.old_file;
          ld_chunk     = res.old_chunk;
          ld_slot      = res.old_slot;
          ld_bytes     = res.old_size;
          ld_last      = 1'b0;
          if (full_r) begin
            ins_slot_nxt = res.old_slot;
            state_nxt    = lcc_pkg::ST_INSERT;
          end else begin
            scan_start = 1'b1;
            state_nxt  = lcc_pkg::ST_SCAN;
          end
        end
      end

      lcc_pkg::ST_INSERT: begin
        if (out_free) begin
          tbl_wr    = 1'b1;
          stamp_nxt = stamp_r + 1'b1;
          out_load  = 1'b1;
          ld_kind   = lcc_pkg::KIND_INSERT;
          ld_file   = file_r;
          ld_chunk  = chunk_r;
          ld_slot   = ins_slot_r;
          ld_bytes  = fetch_r;
          state_nxt = lcc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lcc_pkg::ST_IDLE;
      added_r  <= 1'b0;
      full_r   <= 1'b0;
      stamp_r  <= '0;
      total_r  <= '0;
      budget_r <= lcc_pkg::BUDGET_RESET;
    end else begin
      state_r <= state_nxt;
      added_r <= added_nxt;
      full_r  <= full_nxt;
      stamp_r <= stamp_nxt;
      total_r <= total_nxt;
      // The budget never drops below one chunk.
      if (cfg_we) begin
        budget_r <= (cfg_wdata < CHUNK_BUD) ? CHUNK_BUD : cfg_wdata;
      end
    end
  end

  // Request fields are held for the whole request; oversized fetches clamp.
  always_ff @(posedge clk) begin
    ins_slot_r <= ins_slot_nxt;
    if (accept) begin
      mode_r  <= lcc_pkg::mode_t'(in_mode);
      file_r  <= in_file_id;
      chunk_r <= in_chunk_index;
      fetch_r <= (in_fetched_bytes > CHUNK_SZ) ? CHUNK_SZ : in_fetched_bytes;
    end
  end

  // Result register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= ld_kind;
      out_file_r  <= ld_file;
      out_chunk_r <= ld_chunk;
      out_slot_r  <= SLW'(ld_slot);
      out_bytes_r <= ld_bytes;
      out_count_r <= ld_count;
      out_total_r <= OTW'(total_nxt);
      out_last_r  <= ld_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_file          = out_file_r;
  assign out_chunk         = out_chunk_r;
  assign out_slot          = out_slot_r;
  assign out_entry_bytes   = out_bytes_r;
  assign out_removed_count = out_count_r;
  assign out_total_bytes   = out_total_r;
  assign out_last          = out_last_r;

endmodule

// ===== hdl/lcc_checker.sv =====
// ----------------------------------------------------------------------------
// lcc_checker
// Port-level checks on the chunk cache result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      out_kind,
  input logic [lcc_pkg::COUNT_W-1:0]     out_removed_count,
  input logic [lcc_pkg::TOTAL_OUT_W-1:0] out_total_bytes,
  input logic                            out_last
);

  // A stalled result holds.
  `LCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_total_bytes))

  // Hits and inserts always finish a request.
  `LCC_ASSERT(a_final_kinds, out_valid && (out_kind == lcc_pkg::KIND_HIT || out_kind == lcc_pkg::KIND_INSERT), out_last)

  // An eviction is never the final result and removes no count.
  `LCC_ASSERT(a_evict_mid, out_valid && out_kind == lcc_pkg::KIND_EVICT, !out_last && out_removed_count == '0)

  // Clearing leaves nothing cached.
  `LCC_ASSERT(a_clear_total, out_valid && out_kind == lcc_pkg::KIND_CLEAR, out_total_bytes == '0)

  // A new request starts only once the previous one has produced its final result.
  `LCC_ASSERT(a_accept_after_last, in_valid && in_ready, !out_valid || out_last)

endmodule

bind lru_chunk_cache_byte_budget lcc_checker u_lcc_checker (.*);
